### design/nrle_pkg.sv
// ----------------------------------------------------------------------------
// nrle_pkg
// Types and constants shared by the nullable column run-length encoder.
// ----------------------------------------------------------------------------
package nrle_pkg;

    localparam logic [7:0]  RUN_TAG_NULL  = 8'h00;
    localparam logic [7:0]  RUN_TAG_VALUE = 8'h01;
    localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

    // Bytes in one serialized run: tag + count, or tag + value + count
    localparam int NULL_RUN_BYTES  = 5;
    localparam int VALUE_RUN_BYTES = 13;
    localparam int BYTE_IDX_W      = $clog2(VALUE_RUN_BYTES);
    localparam int RUN_VEC_W       = 8 * VALUE_RUN_BYTES;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [63:0] row_value;
        logic               row_valid;
        logic               final_row;
    } row_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
        logic       end_of_stream;
    } byte_t;

    // One closed run waiting to be serialized
    typedef struct packed {
        logic        is_value;
        logic [63:0] value;
        logic [31:0] length;
        logic        last_of_item;
        logic        end_of_stream;
    } run_desc_t;

endpackage

### design/nrle_front.sv
// ----------------------------------------------------------------------------
// nrle_front
// Keeps the open run, classifies each row and queues closed runs.
// ----------------------------------------------------------------------------
module nrle_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  nrle_pkg::row_t     row,
    output logic               q_push,
    output nrle_pkg::run_desc_t q_data,
    input  logic               q_full
);
    import nrle_pkg::*;

    logic        run_open_reg,     run_open_next;
    logic        run_is_value_reg, run_is_value_next;
    logic [63:0] run_value_reg,    run_value_next;
    logic [31:0] run_length_reg,   run_length_next;
    logic        flush_pending_reg, flush_pending_next;

    logic        accept;
    logic        same;
    logic        extend;
    logic        new_is_value;
    logic [63:0] new_value;
    logic [31:0] new_length;

    assign full   = q_full || flush_pending_reg;
    assign accept = push && !full;

    assign same   = run_open_reg && (run_is_value_reg == row.row_valid) &&
                    (!row.row_valid || (run_value_reg == row.row_value));
    assign extend = same && (run_length_reg != COUNT_MAX);

    always_comb
    begin
        if (extend)
        begin
            new_is_value = run_is_value_reg;
            new_value    = run_value_reg;
            new_length   = run_length_reg + 32'd1;
        end
        else
        begin
            new_is_value = row.row_valid;
            new_value    = row.row_valid ? row.row_value : 64'd0;
            new_length   = 32'd1;
        end
    end

    always_comb
    begin
        run_open_next      = run_open_reg;
        run_is_value_next  = run_is_value_reg;
        run_value_next     = run_value_reg;
        run_length_next    = run_length_reg;
        flush_pending_next = flush_pending_reg;
        q_push             = 1'b0;
        q_data             = '0;

        if (flush_pending_reg)
        begin
            // second run of a final row that also closed a run
            if (!q_full)
            begin
                q_push             = 1'b1;
                q_data             = '{run_is_value_reg, run_value_reg,
                                       run_length_reg, 1'b1, 1'b1};
                run_open_next      = 1'b0;
                run_is_value_next  = 1'b0;
                run_value_next     = 64'd0;
                run_length_next    = 32'd0;
                flush_pending_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (run_open_reg && !extend)
            begin
                q_push             = 1'b1;
                q_data             = '{run_is_value_reg, run_value_reg, run_length_reg,
                                       !row.final_row, 1'b0};
                run_open_next      = 1'b1;
                run_is_value_next  = new_is_value;
                run_value_next     = new_value;
                run_length_next    = new_length;
                flush_pending_next = row.final_row;
            end
            else if (row.final_row)
            begin
                q_push            = 1'b1;
                q_data            = '{new_is_value, new_value, new_length, 1'b1, 1'b1};
                run_open_next     = 1'b0;
                run_is_value_next = 1'b0;
                run_value_next    = 64'd0;
                run_length_next   = 32'd0;
            end
            else
            begin
                run_open_next     = 1'b1;
                run_is_value_next = new_is_value;
                run_value_next    = new_value;
                run_length_next   = new_length;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg      <= 1'b0;
            run_is_value_reg  <= 1'b0;
            run_value_reg     <= 64'd0;
            run_length_reg    <= 32'd0;
            flush_pending_reg <= 1'b0;
        end
        else
        begin
            run_open_reg      <= run_open_next;
            run_is_value_reg  <= run_is_value_next;
            run_value_reg     <= run_value_next;
            run_length_reg    <= run_length_next;
            flush_pending_reg <= flush_pending_next;
        end
    end

endmodule

### design/nrle_queue.sv
// ----------------------------------------------------------------------------
// nrle_queue
// Small FIFO of closed runs between the front and the serializer.
// ----------------------------------------------------------------------------
module nrle_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  nrle_pkg::run_desc_t data_in,
    output logic                full,
    input  logic                pop,
    output nrle_pkg::run_desc_t data_out,
    output logic                empty
);
    import nrle_pkg::*;

    run_desc_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg,  count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full     = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= data_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/nrle_serializer.sv
// ----------------------------------------------------------------------------
// nrle_serializer
// Turns queued runs into little-endian bytes, one per cycle, into an
// output register while that register is empty or being popped.
// ----------------------------------------------------------------------------
module nrle_serializer
(
    input  logic                clk,
    input  logic                rst_n,
    input  nrle_pkg::run_desc_t q_data,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output nrle_pkg::byte_t     result
);
    import nrle_pkg::*;

    logic [BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    byte_t                 out_reg;

    logic                  advance;
    logic                  last_byte;
    logic [RUN_VEC_W-1:0]  run_vec;
    logic [7:0]            cur_byte;

    always_comb
    begin
        if (q_data.is_value)
            run_vec = {q_data.length, q_data.value, RUN_TAG_VALUE};
        else
            run_vec = {(RUN_VEC_W - 40)'(0), q_data.length, RUN_TAG_NULL};
    end

    assign cur_byte  = run_vec[{idx_reg, 3'b000} +: 8];
    assign last_byte = q_data.is_value ?
                       (idx_reg == BYTE_IDX_W'(VALUE_RUN_BYTES - 1)) :
                       (idx_reg == BYTE_IDX_W'(NULL_RUN_BYTES - 1));
    assign advance   = !q_empty && (!out_valid_reg || pop);
    assign q_pop     = advance && last_byte;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            idx_next       = last_byte ? '0 : idx_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.out_byte      <= cur_byte;
            out_reg.last_of_item  <= last_byte && q_data.last_of_item;
            out_reg.end_of_stream <= last_byte && q_data.end_of_stream;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/nullable_column_rle_encoder.sv
// ----------------------------------------------------------------------------
// nullable_column_rle_encoder
// Run-length encoder for a nullable column of signed 64-bit values.
// ----------------------------------------------------------------------------
// Rows go in through a queue-like port (push/full) and encoded bytes come out
// through another (empty/pop), one byte per cycle from a registered output
// while pop keeps it drained. A row that only extends or opens a run makes no
// bytes. A closed null run makes 5 output bytes and a closed value run 13;
// the byte serializer is the limit, so a stream where every row closes a
// value run is held back by it. A final row that also closes a run queues
// two runs (up to 26 bytes) and holds full until the second run is queued.
// A four-entry run queue sits between the row classifier and the serializer
// so rows keep flowing while bytes drain.
// ----------------------------------------------------------------------------
module nullable_column_rle_encoder
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  nrle_pkg::row_t  row,
    output logic            empty,
    input  logic            pop,
    output nrle_pkg::byte_t result
);
    import nrle_pkg::*;

    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    run_desc_t q_wr_data;
    run_desc_t q_rd_data;

    nrle_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .row    (row),
        .q_push (q_push),
        .q_data (q_wr_data),
        .q_full (q_full)
    );

    nrle_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .data_in  (q_wr_data),
        .full     (q_full),
        .pop      (q_pop),
        .data_out (q_rd_data),
        .empty    (q_empty)
    );

    nrle_serializer u_serializer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rd_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
